// ===== design/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// hufd_pkg: shared types for the Huffman tree decoder
// Channel words, item modes, decode phases and the controller/datapath links.
// ----------------------------------------------------------------------------
package hufd_pkg;

  // Width of the running symbol total.
  localparam int SUM_W = 40;

  // Item selector carried in the input word.
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_BUILD = 2'd2,
    MODE_DATA  = 2'd3
  } mode_t;

  // What the decoder currently holds.
  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_TREE   = 2'd1,
    PH_SINGLE = 2'd2
  } phase_t;

  // Input word.
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  symbol;
    logic [31:0] count;
    logic [7:0]  code_byte;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       last_of_item;
    logic       last_of_stream;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic build_start;
    logic leaf_issue;
    logic leaf_done;
    logic merge_issue;
    logic last_issue;
    logic merge_w1;
    logic merge_w2;
    logic dec_start;
    logic walk_issue;
    logic walk_eval;
    logic single_emit;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    phase_t phase;
    logic   rem_zero;
    logic   rem_one;
    logic   leaf_last;
    logic   merge_last;
    logic   n_zero;
    logic   n_one;
    logic   size_two;
    logic   bit_last;
    logic   node_leaf;
    logic   emit_ok;
    logic   out_free;
    logic   pend_vld;
  } sts_t;

endpackage

// ===== design/hufd_datapath.sv =====
// ----------------------------------------------------------------------------
// hufd_datapath: tables, merge search and tree walk of the Huffman decoder
// Holds the count, node and merge memories, the two-least search registers,
// the walk position and the pending and output word registers.
// ----------------------------------------------------------------------------
module hufd_datapath #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hufd_pkg::cmd_t      cmd,
  output hufd_pkg::sts_t      sts,
  input  hufd_pkg::in_word_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output hufd_pkg::out_word_t out_data
);

  localparam int IW       = $clog2(ALPHABET_SIZE);
  localparam int NODE_CAP = 2 * ALPHABET_SIZE;
  localparam int NW       = $clog2(NODE_CAP);
  localparam int CW       = IW + 1;
  localparam int SW       = hufd_pkg::SUM_W;
  localparam int NR_W     = 2 * NW + 9;
  localparam int ME_W     = SW + 1 + NW;
  localparam int L_HI     = NR_W - 1;
  localparam int R_HI     = NR_W - 1 - NW;

  // Count table with one valid bit per symbol.
  logic [31:0]              cnt_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] cnt_vld_r;
  logic [31:0]              cnt_q_r;
  logic                     cnt_qv_r;
  logic                     leaf_vld_r;
  logic [IW-1:0]            li_r;
  logic [IW-1:0]            li_d_r;
  logic                     load_ok;
  logic                     leaf_hit;

  // Node table, merge list and their ports.
  logic [NR_W-1:0] node_mem [NODE_CAP];
  logic [NR_W-1:0] node_q_r;
  logic            node_we;
  logic [NW-1:0]   node_waddr;
  logic [NR_W-1:0] node_wdata;
  logic [NW-1:0]   node_raddr;

  logic [ME_W-1:0] mrg_mem [ALPHABET_SIZE];
  logic [ME_W-1:0] mrg_q_r;
  logic            mrg_vld_r;
  logic            mrg_we;
  logic [IW-1:0]   mrg_waddr;
  logic [ME_W-1:0] mrg_wdata;
  logic [IW-1:0]   mrg_raddr;

  // Build bookkeeping.
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   size_r;
  logic [CW-1:0]   size_dec;
  logic [NW-1:0]   next_r;
  logic [SW-1:0]   total_r;
  logic [IW-1:0]   mj_r;
  logic [IW-1:0]   mj_d_r;
  logic [ME_W-1:0] b1_r;
  logic [ME_W-1:0] b2_r;
  logic [IW-1:0]   i1_r;
  logic [IW-1:0]   i2_r;
  logic            have1_r;
  logic            have2_r;
  logic [ME_W-1:0] last_r;
  logic [ME_W-1:0] merged;
  logic [ME_W-1:0] last_val;
  logic [NR_W-1:0] inode;

  // Decode state.
  hufd_pkg::phase_t phase_r;
  logic [SW-1:0]    rem_r;
  logic [NR_W-1:0]  cur_rec_r;
  logic [NR_W-1:0]  root_rec_r;
  logic [7:0]       single_sym_r;
  logic [7:0]       byte_r;
  logic [2:0]       bit_r;
  logic             emit;
  logic [7:0]       emit_sym;

  // Pending word and output register.
  logic       pend_vld_r;
  logic [7:0] pend_sym_r;
  logic       pend_los_r;
  logic       out_valid_r;
  hufd_pkg::out_word_t out_data_r;
  logic       out_free;
  logic       push;

  assign load_ok  = cmd.load && ({1'b0, in_data.symbol} < 9'(ALPHABET_SIZE));
  assign leaf_hit = leaf_vld_r && cnt_qv_r && (cnt_q_r != 32'd0);
  assign size_dec = size_r - CW'(1);

  // Merged entry sorts as an internal node: the leaf flag is zero.
  assign merged   = {b1_r[ME_W-1 -: SW] + b2_r[ME_W-1 -: SW], 1'b0, next_r};
  assign last_val = (i1_r == size_dec[IW-1:0]) ? merged : mrg_q_r;
  assign inode    = {b1_r[NW-1:0], b2_r[NW-1:0], 8'd0, 1'b0};

  // Count table: write on load, registered read during the leaf scan.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      cnt_mem[in_data.symbol[IW-1:0]] <= in_data.count;
    end
    if (cmd.leaf_issue) begin
      cnt_q_r <= cnt_mem[li_r];
    end
    cnt_qv_r <= cnt_vld_r[li_r];
    li_d_r   <= li_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      leaf_vld_r <= 1'b0;
    end else begin
      leaf_vld_r <= cmd.leaf_issue;
      if (cmd.clear) begin
        cnt_vld_r <= '0;
      end else if (load_ok) begin
        cnt_vld_r[in_data.symbol[IW-1:0]] <= 1'b1;
      end
    end
  end

  // Node table write and read port selection.
  always_comb begin
    node_we    = leaf_hit || cmd.merge_w1;
    node_waddr = leaf_hit ? NW'(n_r) : next_r;
    node_wdata = leaf_hit ? {{NW{1'b0}}, {NW{1'b0}}, 8'(li_d_r), 1'b1} : inode;
    node_raddr = byte_r[7] ? cur_rec_r[R_HI -: NW] : cur_rec_r[L_HI -: NW];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (cmd.walk_issue) begin
      node_q_r <= node_mem[node_raddr];
    end
  end

  // Merge list write and read port selection.
  always_comb begin
    mrg_we    = leaf_hit || cmd.merge_w1 || cmd.merge_w2;
    mrg_waddr = n_r[IW-1:0];
    mrg_wdata = {{(SW-32){1'b0}}, cnt_q_r, 1'b1, NW'(n_r)};
    if (cmd.merge_w1) begin
      mrg_waddr = i1_r;
      mrg_wdata = merged;
    end else if (cmd.merge_w2) begin
      mrg_waddr = i2_r;
      mrg_wdata = last_r;
    end
    mrg_raddr = cmd.merge_issue ? mj_r : size_dec[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mrg_we) begin
      mrg_mem[mrg_waddr] <= mrg_wdata;
    end
    if (cmd.merge_issue || cmd.last_issue) begin
      mrg_q_r <= mrg_mem[mrg_raddr];
    end
    mj_d_r <= mj_r;
  end

  // Build: leaf collection, then repeated two-least search and merge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrg_vld_r <= 1'b0;
      have1_r   <= 1'b0;
      have2_r   <= 1'b0;
      n_r       <= '0;
      size_r    <= '0;
      next_r    <= '0;
      li_r      <= '0;
      mj_r      <= '0;
      total_r   <= '0;
    end else begin
      mrg_vld_r <= cmd.merge_issue;
      if (cmd.build_start) begin
        n_r     <= '0;
        total_r <= '0;
        li_r    <= '0;
      end
      if (cmd.leaf_issue) begin
        li_r <= li_r + IW'(1);
      end
      if (leaf_hit) begin
        n_r     <= n_r + CW'(1);
        total_r <= total_r + SW'(cnt_q_r);
      end
      if (cmd.leaf_done) begin
        size_r  <= n_r;
        next_r  <= NW'(n_r);
        mj_r    <= '0;
        have1_r <= 1'b0;
        have2_r <= 1'b0;
      end
      if (cmd.merge_issue) begin
        mj_r <= mj_r + IW'(1);
      end
      // Keys are unique, so plain vector order gives count, then kind, then age.
      if (mrg_vld_r) begin
        if (!have1_r || (mrg_q_r < b1_r)) begin
          b2_r    <= b1_r;
          i2_r    <= i1_r;
          have2_r <= have1_r;
          b1_r    <= mrg_q_r;
          i1_r    <= mj_d_r;
          have1_r <= 1'b1;
        end else if (!have2_r || (mrg_q_r < b2_r)) begin
          b2_r    <= mrg_q_r;
          i2_r    <= mj_d_r;
          have2_r <= 1'b1;
        end
      end
      if (cmd.merge_w1) begin
        last_r <= last_val;
      end
      if (cmd.merge_w2) begin
        size_r  <= size_dec;
        next_r  <= next_r + NW'(1);
        mj_r    <= '0;
        have1_r <= 1'b0;
        have2_r <= 1'b0;
      end
    end
  end

  // Single-symbol capture and root record.
  always_ff @(posedge clk) begin
    if (leaf_hit && (n_r == '0)) begin
      single_sym_r <= 8'(li_d_r);
    end
    if (cmd.merge_w1) begin
      root_rec_r <= inode;
    end
  end

  // Emission of one symbol.
  assign emit     = (cmd.walk_eval && node_q_r[0]) || cmd.single_emit;
  assign emit_sym = cmd.single_emit ? single_sym_r : node_q_r[8:1];
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (emit && pend_vld_r) || cmd.flush;

  // Decode state: phase, remaining total, walk position and bit position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hufd_pkg::PH_NONE;
      rem_r   <= '0;
      bit_r   <= '0;
    end else begin
      if (cmd.clear) begin
        phase_r <= hufd_pkg::PH_NONE;
        rem_r   <= '0;
      end
      if (cmd.leaf_done) begin
        rem_r <= total_r;
        if (n_r == '0) begin
          phase_r <= hufd_pkg::PH_NONE;
        end else if (n_r == CW'(1)) begin
          phase_r <= hufd_pkg::PH_SINGLE;
        end
      end
      if (cmd.merge_w2 && (size_r == CW'(2))) begin
        phase_r <= hufd_pkg::PH_TREE;
      end
      if (cmd.dec_start) begin
        bit_r <= '0;
      end
      if (cmd.walk_eval || cmd.single_emit) begin
        bit_r <= bit_r + 3'd1;
      end
      if (emit) begin
        rem_r <= rem_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_w1) begin
      cur_rec_r <= inode;
    end else if (cmd.walk_eval) begin
      cur_rec_r <= node_q_r[0] ? root_rec_r : node_q_r;
    end
    if (cmd.dec_start) begin
      byte_r <= in_data.code_byte;
    end else if (cmd.walk_eval) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
  end

  // Pending word: held back until the item's last symbol is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_sym_r <= emit_sym;
      pend_los_r <= (rem_r == SW'(1));
    end
    if (push) begin
      out_data_r.decoded_symbol <= pend_sym_r;
      out_data_r.last_of_item   <= cmd.flush;
      out_data_r.last_of_stream <= pend_los_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status back to the controller.
  always_comb begin
    sts.phase      = phase_r;
    sts.rem_zero   = (rem_r == '0);
    sts.rem_one    = (rem_r == SW'(1));
    sts.leaf_last  = (li_r == IW'(ALPHABET_SIZE - 1));
    sts.merge_last = (mj_r == size_dec[IW-1:0]);
    sts.n_zero     = (n_r == '0);
    sts.n_one      = (n_r == CW'(1));
    sts.size_two   = (size_r == CW'(2));
    sts.bit_last   = (bit_r == 3'd7);
    sts.node_leaf  = node_q_r[0];
    sts.emit_ok    = !pend_vld_r || out_free;
    sts.out_free   = out_free;
    sts.pend_vld   = pend_vld_r;
  end

endmodule

// ===== design/hufd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hufd_ctrl: sequencing state machine of the Huffman decoder
// Accepts one input word at a time and steps the datapath through the table
// scan, the merge passes and the bit-by-bit tree walk.
// ----------------------------------------------------------------------------
module hufd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  hufd_pkg::mode_t in_mode,
  output logic            in_stall,
  input  hufd_pkg::sts_t  sts,
  output hufd_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LSCAN  = 13'b0000000000010,
    S_LDRAIN = 13'b0000000000100,
    S_LDONE  = 13'b0000000001000,
    S_MSCAN  = 13'b0000000010000,
    S_MDRAIN = 13'b0000000100000,
    S_MLAST  = 13'b0000001000000,
    S_MWR1   = 13'b0000010000000,
    S_MWR2   = 13'b0000100000000,
    S_WALK   = 13'b0001000000000,
    S_WEVAL  = 13'b0010000000000,
    S_SINGLE = 13'b0100000000000,
    S_FLUSH  = 13'b1000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            hufd_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            hufd_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            hufd_pkg::MODE_BUILD: begin
              cmd.build_start = 1'b1;
              state_nxt       = S_LSCAN;
            end
            hufd_pkg::MODE_DATA: begin
              if (sts.phase != hufd_pkg::PH_NONE && !sts.rem_zero) begin
                cmd.dec_start = 1'b1;
                state_nxt = (sts.phase == hufd_pkg::PH_TREE) ? S_WALK : S_SINGLE;
              end
            end
          endcase
        end
      end
      S_LSCAN: begin
        cmd.leaf_issue = 1'b1;
        if (sts.leaf_last) begin
          state_nxt = S_LDRAIN;
        end
      end
      S_LDRAIN: state_nxt = S_LDONE;
      S_LDONE: begin
        cmd.leaf_done = 1'b1;
        state_nxt = (sts.n_zero || sts.n_one) ? S_IDLE : S_MSCAN;
      end
      S_MSCAN: begin
        cmd.merge_issue = 1'b1;
        if (sts.merge_last) begin
          state_nxt = S_MDRAIN;
        end
      end
      S_MDRAIN: state_nxt = S_MLAST;
      S_MLAST: begin
        cmd.last_issue = 1'b1;
        state_nxt      = S_MWR1;
      end
      S_MWR1: begin
        cmd.merge_w1 = 1'b1;
        state_nxt    = S_MWR2;
      end
      S_MWR2: begin
        cmd.merge_w2 = 1'b1;
        state_nxt    = sts.size_two ? S_IDLE : S_MSCAN;
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        state_nxt      = S_WEVAL;
      end
      S_WEVAL: begin
        // A leaf needs room for its word; an inner node never waits.
        if (!sts.node_leaf || sts.emit_ok) begin
          cmd.walk_eval = 1'b1;
          if (sts.bit_last || (sts.node_leaf && sts.rem_one)) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_SINGLE: begin
        if (sts.emit_ok) begin
          cmd.single_emit = 1'b1;
          if (sts.bit_last || sts.rem_one) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_vld) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder: Huffman table build and byte-stream decoder
// The input channel takes one word per item: clear, load a count, build the
// tree, or one compressed byte. The output channel gives one word per symbol,
// flagged as last of its item and last of the stream.
// Clear and load are done without leaving the idle state. Build scans all
// ALPHABET_SIZE count entries and then makes n - 1 merges for n used symbols,
// each a pass over the live merge list of s entries, read one entry at a time
// through the single merge-list read port.
// A compressed byte is walked bit by bit through the node memory, a read state
// and an evaluate state per bit, and a flush state then releases the held-back
// last symbol; with a single symbol it gives one copy per code bit. Items are
// taken one at a time.
// Reset empties the count table and leaves no tree. A stalled output holds
// its word; one more symbol is held in a pending register, after which the
// walk waits at the next leaf until the output frees.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hufd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hufd_pkg::out_word_t out_data
);

  hufd_pkg::cmd_t cmd;
  hufd_pkg::sts_t sts;

  // Sequencer.
  hufd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, search and walk.
  hufd_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== test/huffman_tree_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_tb: self-checking bench for the Huffman tree decoder
// Words are sent from a queue of pending items through a clocked driver. A
// monitor rebuilds the table and tree on its own and walks every compressed
// byte, so each symbol that leaves the block is checked in order, field by
// field. Both sides idle at random in changing proportions.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_tb;

  localparam int ALPHA      = 256;
  localparam int NODES      = 2 * ALPHA;
  localparam int IDLE_LIMIT = 200000;
  localparam int SUM_W      = hufd_pkg::SUM_W;

  typedef struct {
    hufd_pkg::in_word_t word;
    bit                 drain;
  } pending_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hufd_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hufd_pkg::out_word_t out_data;

  pending_t            pending_words[$];
  hufd_pkg::out_word_t expected_syms[$];
  int                  sent_words;
  int                  idle_cycles;
  bit                  in_took;
  bit                  failed;

  // Shadow of the decoder state.
  logic [31:0]       sym_count[ALPHA];
  int                node_left[NODES];
  int                node_right[NODES];
  logic [7:0]        node_sym[NODES];
  bit                node_leaf[NODES];
  logic [40:0]       pool_count[ALPHA];
  int                pool_node[ALPHA];
  int                walk_node;
  int                root_idx;
  logic [SUM_W-1:0]  left_to_emit;
  hufd_pkg::phase_t  tree_phase;

  huffman_tree_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lower count first, then internal before leaf, then byte or age.
  function automatic bit pool_less(int a, int b);
    int na;
    int nb;
    na = pool_node[a];
    nb = pool_node[b];
    if (pool_count[a] != pool_count[b]) return pool_count[a] < pool_count[b];
    if (node_leaf[na] != node_leaf[nb]) return !node_leaf[na];
    if (node_leaf[na]) return node_sym[na] < node_sym[nb];
    return na < nb;
  endfunction

  // Turn the count table into a tree by repeated least-pair merges.
  function automatic void build_code_tree();
    int n;
    int live;
    int fresh;
    int lo;
    int second;
    n = 0;
    left_to_emit = '0;
    for (int i = 0; i < ALPHA; i++) begin
      if (sym_count[i] != 0) begin
        node_leaf[n]  = 1'b1;
        node_sym[n]   = i[7:0];
        node_left[n]  = 0;
        node_right[n] = 0;
        pool_count[n] = 41'(sym_count[i]);
        pool_node[n]  = n;
        left_to_emit  = left_to_emit + SUM_W'(sym_count[i]);
        n++;
      end
    end
    walk_node = 0;
    root_idx  = 0;
    if (n == 0) begin
      tree_phase = hufd_pkg::PH_NONE;
      return;
    end
    if (n == 1) begin
      tree_phase = hufd_pkg::PH_SINGLE;
      return;
    end
    live  = n;
    fresh = n;
    while (live > 1) begin
      lo = 0;
      for (int i = 1; i < live; i++) if (pool_less(i, lo)) lo = i;
      second = (lo == 0) ? 1 : 0;
      for (int i = 0; i < live; i++) if (i != lo && pool_less(i, second)) second = i;
      node_leaf[fresh]  = 1'b0;
      node_sym[fresh]   = 8'd0;
      node_left[fresh]  = pool_node[lo];
      node_right[fresh] = pool_node[second];
      pool_count[lo]    = pool_count[lo] + pool_count[second];
      pool_node[lo]     = fresh;
      live--;
      pool_count[second] = pool_count[live];
      pool_node[second]  = pool_node[live];
      fresh++;
    end
    root_idx   = fresh - 1;
    walk_node  = root_idx;
    tree_phase = hufd_pkg::PH_TREE;
  endfunction

  // Apply one accepted word and queue the symbols it should produce.
  function automatic void decode_word(hufd_pkg::in_word_t w);
    hufd_pkg::out_word_t got[$];
    hufd_pkg::out_word_t o;
    int                  nxt;
    case (w.mode)
      hufd_pkg::MODE_CLEAR: begin
        foreach (sym_count[i]) sym_count[i] = '0;
        tree_phase   = hufd_pkg::PH_NONE;
        left_to_emit = '0;
        walk_node    = 0;
      end
      hufd_pkg::MODE_LOAD: sym_count[w.symbol] = w.count;
      hufd_pkg::MODE_BUILD: build_code_tree();
      default: begin
        if (tree_phase != hufd_pkg::PH_NONE && left_to_emit != 0) begin
          for (int b = 0; b < 8 && left_to_emit != 0; b++) begin
            if (tree_phase == hufd_pkg::PH_SINGLE) begin
              o.decoded_symbol = node_sym[0];
              left_to_emit--;
              o.last_of_item   = 1'b0;
              o.last_of_stream = (left_to_emit == 0);
              got.push_back(o);
            end else begin
              nxt = w.code_byte[7-b] ? node_right[walk_node] : node_left[walk_node];
              if (node_leaf[nxt]) begin
                o.decoded_symbol = node_sym[nxt];
                left_to_emit--;
                o.last_of_item   = 1'b0;
                o.last_of_stream = (left_to_emit == 0);
                got.push_back(o);
                nxt = root_idx;
              end
              walk_node = nxt;
            end
          end
          if (got.size() > 0) got[got.size()-1].last_of_item = 1'b1;
          foreach (got[i]) expected_syms.push_back(got[i]);
        end
      end
    endcase
  endfunction

  // Idle rates: sender 14 / receiver 80, then swapped, then none.
  function automatic bit sender_rests();
    if (sent_words < 120) return $urandom_range(99) < 14;
    if (sent_words < 240) return $urandom_range(99) < 80;
    return 1'b0;
  endfunction

  function automatic bit receiver_rests();
    if (sent_words < 120) return $urandom_range(99) < 80;
    if (sent_words < 240) return $urandom_range(99) < 14;
    return 1'b0;
  endfunction

  // Input driver, changes on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= receiver_rests();
      if (!in_valid || in_took) begin
        if (pending_words.size() != 0 && !sender_rests() &&
            !(pending_words[0].drain && expected_syms.size() != 0)) begin
          in_data  <= pending_words[0].word;
          in_valid <= 1'b1;
          void'(pending_words.pop_front());
          sent_words++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and scoreboard, sampled on the rising edge.
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) decode_word(in_data);
      if (out_valid && !out_stall) begin
        if (expected_syms.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_data);
          failed = 1'b1;
        end else if (expected_syms[0] !== out_data) begin
          $display("%0t: mismatch expected sym %h item %b stream %b, actual %h %b %b",
                   $time, expected_syms[0].decoded_symbol,
                   expected_syms[0].last_of_item, expected_syms[0].last_of_stream,
                   out_data.decoded_symbol, out_data.last_of_item,
                   out_data.last_of_stream);
          failed = 1'b1;
          void'(expected_syms.pop_front());
        end else begin
          void'(expected_syms.pop_front());
        end
      end
      if (in_took || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Build one word with the given mode and every other field random.
  function automatic hufd_pkg::in_word_t any_word(hufd_pkg::mode_t m);
    hufd_pkg::in_word_t w;
    w.mode      = m;
    w.symbol    = 8'($urandom_range(255));
    w.count     = $urandom;
    w.code_byte = 8'($urandom_range(255));
    return w;
  endfunction

  task automatic queue_word(hufd_pkg::in_word_t w, bit drain = 1'b0);
    pending_t p;
    p.word  = w;
    p.drain = drain;
    pending_words.push_back(p);
  endtask

  task automatic queue_load(int s, logic [31:0] c);
    hufd_pkg::in_word_t w;
    w        = any_word(hufd_pkg::MODE_LOAD);
    w.symbol = 8'(s);
    w.count  = c;
    queue_word(w);
  endtask

  task automatic queue_byte(logic [7:0] b);
    hufd_pkg::in_word_t w;
    w           = any_word(hufd_pkg::MODE_DATA);
    w.code_byte = b;
    queue_word(w);
  endtask

  // Stimulus and end of run.
  initial begin
    int k;
    int total;
    int nbytes;
    bit full_done;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    sent_words  = 0;
    idle_cycles = 0;
    failed      = 1'b0;
    in_took     = 1'b0;
    full_done   = 1'b0;
    foreach (sym_count[i]) sym_count[i] = '0;
    tree_phase   = hufd_pkg::PH_NONE;
    left_to_emit = '0;
    walk_node    = 0;
    root_idx     = 0;

    // Directed: no tree, extreme counts, two-symbol tree, load after build.
    queue_byte(8'hA5);
    queue_load(0, 32'hFFFF_FFFF);
    queue_load(255, 32'hFFFF_FFFF);
    queue_word(any_word(hufd_pkg::MODE_BUILD));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_load(17, 32'd3);
    queue_byte(8'h5A);
    // Single symbol: full bytes, then a partial one, then an ignored byte.
    queue_word(any_word(hufd_pkg::MODE_CLEAR));
    queue_load(7, 32'd20);
    queue_word(any_word(hufd_pkg::MODE_BUILD));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h3C);
    queue_byte(8'h81);
    // Empty table, and a zero count that removes a symbol.
    queue_word(any_word(hufd_pkg::MODE_CLEAR));
    queue_word(any_word(hufd_pkg::MODE_BUILD));
    queue_byte(8'h55);
    queue_load(3, 32'd2);
    queue_load(9, 32'd1);
    queue_load(200, 32'd1);
    queue_load(9, 32'd0);
    queue_word(any_word(hufd_pkg::MODE_BUILD), 1'b1);
    queue_byte(8'hB6);
    queue_byte(8'hFF);

    // Random well-formed streams, with the odd stray word.
    while (pending_words.size() < 360) begin
      queue_word(any_word(hufd_pkg::MODE_CLEAR));
      total = 0;
      if (!full_done && pending_words.size() > 60) begin
        // One stream over the whole alphabet.
        full_done = 1'b1;
        for (int s = 0; s < ALPHA; s++) queue_load(s, $urandom_range(1000, 1));
        total = 1000;
      end else begin
        k = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(9) == 0) begin
            queue_load($urandom_range(255), $urandom);
            total += 40;
          end else begin
            queue_load($urandom_range(255), $urandom_range(6, 1));
            total += 6;
          end
        end
      end
      if ($urandom_range(3) == 0) begin
        queue_word(any_word(hufd_pkg::mode_t'($urandom_range(2))));
      end
      queue_word(any_word(hufd_pkg::MODE_BUILD), pending_words.size() > 300 &&
                 pending_words.size() < 312);
      nbytes = $urandom_range((total < 24) ? total : 24, 2);
      for (int i = 0; i < nbytes; i++) queue_byte(8'($urandom_range(255)));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then let the pipeline settle.
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_syms.size() != 0);
    repeat (40) @(posedge clk);
    if (!failed && expected_syms.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hufd_pkg.sv
design/hufd_datapath.sv
design/hufd_ctrl.sv
design/huffman_tree_decoder.sv
test/huffman_tree_decoder_tb.sv
